// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property on every rising clock edge while reset is released.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checks that an expression is never true while reset is released.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

// ===== hdl/hls2rgb_pkg.sv =====
`default_nettype none

package hls2rgb_pkg;

  // One hue, lightness, saturation triple.
  typedef struct packed {
    logic [12:0] hue_deg16;
    logic [8:0]  lightness;
    logic [8:0]  saturation;
  } hls_in_t;

  // One converted color.
  typedef struct packed {
    logic [15:0] red_level;
    logic [15:0] green_level;
    logic [15:0] blue_level;
  } rgb_out_t;

  // Hue landmarks in 1/16 degree.
  localparam logic [13:0] HueFull  = 14'd5760;
  localparam logic [13:0] HueThird = 14'd1920;
  localparam logic [12:0] HueRise  = 13'd960;
  localparam logic [12:0] HueTop   = 13'd2880;
  localparam logic [12:0] HueFall  = 13'd3840;

  // 1.0 and 0.5 in lightness and saturation units.
  localparam logic [8:0] OneLs  = 9'd256;
  localparam logic [8:0] HalfLs = 9'd128;

  // Half of the divisor 960 * 65536, used for round half up.
  localparam logic [33:0] RoundHalf = 34'd31457280;

  // The divisor is 15 * 2^22: shift by 22, then divide by 15 through
  // multiplication by ceil(65536 / 15). Exact for quotients below 4681.
  localparam int unsigned DivShift  = 22;
  localparam logic [12:0] RecipFift = 13'd4370;

endpackage

`default_nettype wire

// ===== hdl/hls_to_rgb_converter.sv =====
// HLS to RGB converter, fully pipelined, five register stages.
// A result appears on result_o with done_o high after passing stage registers
// s1 to s4 and the output register; it is transferred at the edge after that.
// Throughput: one triple per clock cycle; busy stays low, and the receiver
// cannot stall. Reset (rst_ni low, asynchronous) clears only the valid bits.
`default_nettype none

`include "assert_macros.svh"

module hls_to_rgb_converter
  import hls2rgb_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire hls_in_t  in_i,
  output logic          done_o,
  output rgb_out_t      result_o
);

  // Channels are kept as three lanes: index 0 red, 1 green, 2 blue.
  localparam int unsigned NumChan = 3;

  // Wraps a hue position, given with a non-negative offset, back into the
  // range 0..5759. Two conditional subtractions cover every 13-bit hue.
  function automatic logic [12:0] wrap_pos(input logic [13:0] p);
    logic [13:0] w;
    w = p;
    if (w >= HueFull) begin
      w = w - HueFull;
    end
    if (w >= HueFull) begin
      w = w - HueFull;
    end
    return w[12:0];
  endfunction

  // Weight of the piecewise hue ramp at position x, 0..960.
  function automatic logic [9:0] ramp_weight(input logic [12:0] x);
    logic [12:0] w;
    if (x < HueRise) begin
      w = x;
    end else if (x < HueTop) begin
      w = HueRise;
    end else if (x < HueFall) begin
      w = HueFall - x;
    end else begin
      w = '0;
    end
    return w[9:0];
  endfunction

  // The block never holds off the sender: every stage advances each cycle.
  assign busy = 1'b0;

  logic in_xfer;
  assign in_xfer = start && !busy;

  // ---------------------------------------------------------------------
  // Stage 1: saturate lightness and saturation to 1.0, form L*S, and place
  // the three ramp positions (hue + 120, hue, hue - 120 degrees). The blue
  // position is taken as hue + 240 degrees, which wraps to the same place.
  // ---------------------------------------------------------------------
  logic        s1_valid_q;
  logic [8:0]  s1_lt_d, s1_lt_q;
  logic [8:0]  s1_sat_d, s1_sat_q;
  logic [16:0] s1_ls_d, s1_ls_q;
  logic [12:0] s1_pos_d [NumChan];
  logic [12:0] s1_pos_q [NumChan];

  always_comb begin
    s1_lt_d  = (in_i.lightness > OneLs) ? OneLs : in_i.lightness;
    s1_sat_d = (in_i.saturation > OneLs) ? OneLs : in_i.saturation;
    s1_ls_d  = 17'({9'd0, s1_lt_d} * {9'd0, s1_sat_d});
    s1_pos_d[0] = wrap_pos({1'b0, in_i.hue_deg16} + HueThird);
    s1_pos_d[1] = wrap_pos({1'b0, in_i.hue_deg16});
    s1_pos_d[2] = wrap_pos({1'b0, in_i.hue_deg16} + HueThird + HueThird);
  end

  // ---------------------------------------------------------------------
  // Stage 2: the HLS rule gives m2 and m1 with 16 fraction bits. Both stay
  // within 0..65536 and m2 never falls below m1, so the ramp slope m2 - m1
  // is unsigned. The ramp weight of each channel is looked up in parallel.
  // ---------------------------------------------------------------------
  logic        s2_valid_q;
  logic [17:0] s2_m2_wide;
  logic [17:0] s2_m1_wide;
  logic [16:0] s2_m1_d, s2_m1_q;
  logic [16:0] s2_diff_d, s2_diff_q;
  logic [9:0]  s2_t_d [NumChan];
  logic [9:0]  s2_t_q [NumChan];

  always_comb begin
    if (s1_lt_q <= HalfLs) begin
      s2_m2_wide = {1'b0, s1_lt_q, 8'd0} + {1'b0, s1_ls_q};
    end else begin
      s2_m2_wide = {1'b0, s1_lt_q, 8'd0} + {1'b0, s1_sat_q, 8'd0} - {1'b0, s1_ls_q};
    end
    s2_m1_wide = {s1_lt_q, 9'd0} - s2_m2_wide;
    s2_m1_d    = s2_m1_wide[16:0];
    s2_diff_d  = s2_m2_wide[16:0] - s2_m1_wide[16:0];
    for (int c = 0; c < NumChan; c++) begin
      s2_t_d[c] = ramp_weight(s1_pos_q[c]);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: channel numerator 960*m1 + t*(m2 - m1), at most 960 * 65536.
  // One 17 x 10 multiplier per lane; 960*m1 is two shifts and a subtract.
  // ---------------------------------------------------------------------
  logic        s3_valid_q;
  logic [26:0] s3_base;
  logic [26:0] s3_prod [NumChan];
  logic [25:0] s3_num_d [NumChan];
  logic [25:0] s3_num_q [NumChan];

  always_comb begin
    s3_base = {s2_m1_q, 10'd0} - {4'd0, s2_m1_q, 6'd0};
    for (int c = 0; c < NumChan; c++) begin
      s3_prod[c]  = {10'd0, s2_diff_q} * {17'd0, s2_t_q[c]};
      s3_num_d[c] = 26'(s3_base + s3_prod[c]);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: scale by 255, add half the divisor, and drop the 2^22 factor
  // of the divisor. What remains is below 4096 and still needs a /15.
  // ---------------------------------------------------------------------
  logic        s4_valid_q;
  logic [33:0] s4_scaled [NumChan];
  logic [11:0] s4_quot_d [NumChan];
  logic [11:0] s4_quot_q [NumChan];

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      s4_scaled[c] = {s3_num_q[c], 8'd0} - {8'd0, s3_num_q[c]} + RoundHalf;
      s4_quot_d[c] = s4_scaled[c][DivShift +: 12];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: divide by 15 through the reciprocal, giving the 8-bit code.
  // Times 257 is the code repeated in both bytes. An all-black color is
  // replaced by full white before the output register.
  // ---------------------------------------------------------------------
  logic        out_valid_q;
  logic [24:0] s5_recip [NumChan];
  logic [7:0]  s5_code [NumChan];
  rgb_out_t    result_d, result_q;

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      s5_recip[c] = {13'd0, s4_quot_q[c]} * {12'd0, RecipFift};
      s5_code[c]  = s5_recip[c][23:16];
    end
    if (s5_code[0] == 8'd0 && s5_code[1] == 8'd0 && s5_code[2] == 8'd0) begin
      result_d.red_level   = '1;
      result_d.green_level = '1;
      result_d.blue_level  = '1;
    end else begin
      result_d.red_level   = {s5_code[0], s5_code[0]};
      result_d.green_level = {s5_code[1], s5_code[1]};
      result_d.blue_level  = {s5_code[2], s5_code[2]};
    end
  end

  // Valid bits travel alongside the data and are the only reset state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= in_xfer;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= s4_valid_q;
    end
  end

  // Payload registers load only with a valid item, which saves toggling.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_lt_q  <= s1_lt_d;
      s1_sat_q <= s1_sat_d;
      s1_ls_q  <= s1_ls_d;
      for (int c = 0; c < NumChan; c++) begin
        s1_pos_q[c] <= s1_pos_d[c];
      end
    end
    if (s1_valid_q) begin
      s2_m1_q   <= s2_m1_d;
      s2_diff_q <= s2_diff_d;
      for (int c = 0; c < NumChan; c++) begin
        s2_t_q[c] <= s2_t_d[c];
      end
    end
    if (s2_valid_q) begin
      for (int c = 0; c < NumChan; c++) begin
        s3_num_q[c] <= s3_num_d[c];
      end
    end
    if (s3_valid_q) begin
      for (int c = 0; c < NumChan; c++) begin
        s4_quot_q[c] <= s4_quot_d[c];
      end
    end
    if (s4_valid_q) begin
      result_q <= result_d;
    end
  end

  assign done_o   = out_valid_q;
  assign result_o = result_q;

  // Every accepted triple comes out with done_o high after the full pipeline.
  `ASSERT_PROP(a_latency, clk_i, rst_ni, in_xfer |-> ##5 done_o, "result missing after transfer")

  // Black never leaves the block; it is replaced by white.
  `ASSERT_NEVER(a_no_black, clk_i, rst_ni,
    done_o && result_o.red_level == '0 && result_o.green_level == '0 && result_o.blue_level == '0,
    "all-black result transferred")

  // Each level is an 8-bit code times 257, so both bytes agree.
  `ASSERT_PROP(a_byte_copy, clk_i, rst_ni,
    done_o |-> (result_o.red_level[15:8] == result_o.red_level[7:0]
      && result_o.green_level[15:8] == result_o.green_level[7:0]
      && result_o.blue_level[15:8] == result_o.blue_level[7:0]),
    "level is not a code times 257")

endmodule

`default_nettype wire
